>>> sv/fjc_pkg.sv
// Package: shared word types, register codes and constants for the feeder fire and jam control.
package fjc_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 20;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_POWER_CEILING   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_MARGIN   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPOST_MARGIN  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SINGLE_STEP     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_STALL_CURRENT   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_STALL_SPEED     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_STALL_TICKS     = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_TICKS   = 3'd7;

  // fire modes
  localparam logic [1:0] FIRE_IDLE   = 2'd0;
  localparam logic [1:0] FIRE_SINGLE = 2'd1;
  localparam logic [1:0] FIRE_BURST  = 2'd2;

  // jam kinds
  localparam logic [1:0] JAM_NONE   = 2'd0;
  localparam logic [1:0] JAM_SINGLE = 2'd1;
  localparam logic [1:0] JAM_BURST  = 2'd2;

  // drive modes
  localparam logic [1:0] DRIVE_OFF      = 2'd0;
  localparam logic [1:0] DRIVE_POSITION = 2'd1;
  localparam logic [1:0] DRIVE_SPEED    = 2'd2;

  // wheel codes
  localparam logic [1:0] WHEEL_CENTER = 2'd0;
  localparam logic [1:0] WHEEL_SHORT  = 2'd1;
  localparam logic [1:0] WHEEL_LONG   = 2'd2;

  localparam logic [4:0]  RATE_FULL      = 5'd20;
  localparam logic [4:0]  RATE_OUTPOST   = 5'd12;
  localparam logic [4:0]  RATE_NONE      = 5'd0;
  localparam logic [12:0] SPEED_PER_RATE = 13'd270;
  localparam logic signed [32:0] HANDOVER_BACKLOG = -33'sd1400;
  localparam logic [31:0] SETTLE_WINDOW    = 32'd1000;
  localparam logic [31:0] SHOT_DONE_WINDOW = 32'd500;
  localparam logic [12:0] SPEED_TARGET_MAX = 13'd5400;

  typedef struct packed {
    logic [15:0] power_ceiling;
    logic [15:0] normal_power_margin;
    logic [15:0] outpost_power_margin;
    logic [19:0] single_shot_step;
    logic [14:0] stall_current_limit;
    logic [14:0] stall_speed_limit;
    logic [15:0] stall_tick_limit;
    logic [15:0] release_tick_limit;
  } cfg_t;

  typedef struct packed {
    logic               link_ok;
    logic               shoot_armed;
    logic               shoot_full;
    logic               pc_mode;
    logic [1:0]         wheel_code;
    logic               vision_lock;
    logic               vision_fire;
    logic               target_outpost;
    logic [15:0]        shot_power;
    logic signed [31:0] motor_position;
    logic signed [15:0] motor_speed;
    logic signed [15:0] motor_current;
  } in_t;

  typedef struct packed {
    logic [1:0]         shot_mode;
    logic [1:0]         drive_mode;
    logic signed [31:0] position_target;
    logic [12:0]        speed_target;
    logic               jam_active;
  } out_t;

endpackage

>>> sv/fjc_cfg.sv
// Configuration register file of the feeder fire and jam control.
module fjc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [fjc_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [fjc_pkg::CFG_DATA_W-1:0]  wr_data,
  output fjc_pkg::cfg_t                  cfg
);
  import fjc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.power_ceiling        <= 16'd400;
      cfg.normal_power_margin  <= 16'd80;
      cfg.outpost_power_margin <= 16'd250;
      cfg.single_shot_step     <= 20'd32700;
      cfg.stall_current_limit  <= 15'd7000;
      cfg.stall_speed_limit    <= 15'd50;
      cfg.stall_tick_limit     <= 16'd70;
      cfg.release_tick_limit   <= 16'd50;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_POWER_CEILING:  cfg.power_ceiling        <= wr_data[15:0];
        REG_NORMAL_MARGIN:  cfg.normal_power_margin  <= wr_data[15:0];
        REG_OUTPOST_MARGIN: cfg.outpost_power_margin <= wr_data[15:0];
        REG_SINGLE_STEP:    cfg.single_shot_step     <= wr_data;
        REG_STALL_CURRENT:  cfg.stall_current_limit  <= wr_data[14:0];
        REG_STALL_SPEED:    cfg.stall_speed_limit    <= wr_data[14:0];
        REG_STALL_TICKS:    cfg.stall_tick_limit     <= wr_data[15:0];
        REG_RELEASE_TICKS:  cfg.release_tick_limit   <= wr_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

>>> sv/fjc_core.sv
// Tick logic: mode choice, jam detection, jam recovery and fire control with their state.
module fjc_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  fjc_pkg::cfg_t cfg,
  input  fjc_pkg::in_t  item,
  output fjc_pkg::out_t res
);
  import fjc_pkg::*;

  // state
  logic [1:0]  fire_before, fire_before_next;
  logic [31:0] tgt_pos, tgt_pos_next;
  logic [12:0] tgt_speed, tgt_speed_next;
  logic        single_req, single_req_next;
  logic        jam_flag, jam_flag_next;
  logic [1:0]  jam_kind, jam_kind_next;
  logic        rec_done, rec_done_next;
  logic        rec_started, rec_started_next;
  logic [15:0] stall_ticks, stall_ticks_next;
  logic [15:0] release_ticks, release_ticks_next;

  logic [1:0]  fire_now;
  logic [4:0]  rate;
  logic        healthy;
  logic        straining;
  logic        is_single;
  logic [15:0] need_margin;

  // |target - position| below a window, on exact signed values
  function automatic logic gap_below(input logic [31:0] tp, input logic [31:0] pos,
                                     input logic [31:0] win);
    logic signed [32:0] d;
    logic signed [32:0] w;
    d = $signed({tp[31], tp}) - $signed({pos[31], pos});
    w = $signed({1'b0, win});
    return (d < w) && (d > -w);
  endfunction

  // power at or above ceiling minus margin
  function automatic logic power_short(input logic [15:0] power, input logic [15:0] margin,
                                       input logic [15:0] ceiling);
    return ({1'b0, power} + {1'b0, margin}) >= {1'b0, ceiling};
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  always_comb begin
    fire_before_next   = fire_before;
    tgt_pos_next       = tgt_pos;
    tgt_speed_next     = tgt_speed;
    single_req_next    = single_req;
    jam_flag_next      = jam_flag;
    jam_kind_next      = jam_kind;
    rec_done_next      = rec_done;
    rec_started_next   = rec_started;
    stall_ticks_next   = stall_ticks;
    release_ticks_next = release_ticks;
    rate               = RATE_NONE;
    is_single          = 1'b0;
    need_margin        = 16'd0;

    // mode choice
    healthy = item.link_ok && item.shoot_armed;
    if (!healthy) begin
      fire_now     = FIRE_IDLE;
      tgt_pos_next = item.motor_position;
    end else if (item.pc_mode && item.vision_lock) begin
      fire_now = FIRE_BURST;
    end else begin
      case (item.wheel_code)
        WHEEL_CENTER: begin
          fire_now        = FIRE_IDLE;
          single_req_next = 1'b1;
        end
        WHEEL_SHORT: fire_now = FIRE_SINGLE;
        WHEEL_LONG: begin
          if (fire_before == FIRE_SINGLE &&
              ($signed({item.motor_position[31], item.motor_position}) -
               $signed({tgt_pos[31], tgt_pos})) <= HANDOVER_BACKLOG)
            fire_now = FIRE_SINGLE;
          else
            fire_now = FIRE_BURST;
        end
        default: fire_now = FIRE_IDLE;
      endcase
    end

    // jam detection: high current at low non-negative speed
    straining = !item.motor_current[15] &&
                (item.motor_current[14:0] > cfg.stall_current_limit) &&
                !item.motor_speed[15] &&
                (item.motor_speed[14:0] < cfg.stall_speed_limit) && !jam_flag;
    stall_ticks_next = straining ? sat_inc(stall_ticks) : 16'd0;
    if (stall_ticks_next > cfg.stall_tick_limit) begin
      jam_flag_next = 1'b1;
      jam_kind_next = (fire_now == FIRE_BURST) ? JAM_BURST : JAM_SINGLE;
      rec_done_next = 1'b0;
    end
    if (!jam_flag_next && rec_started) rec_started_next = 1'b0;

    // fire control
    if (!item.shoot_full) begin
      tgt_pos_next = item.motor_position;
    end else begin
      need_margin = item.target_outpost ? cfg.outpost_power_margin : cfg.normal_power_margin;
      if (!item.pc_mode)
        rate = RATE_FULL;
      else
        rate = power_short(item.shot_power, need_margin, cfg.power_ceiling)
               ? RATE_NONE : RATE_FULL;

      if (!rec_done_next) begin
        if (jam_kind_next == JAM_SINGLE || jam_kind_next == JAM_BURST) begin
          is_single = (jam_kind_next == JAM_SINGLE);
          if (!rec_started_next) begin
            tgt_pos_next     = item.motor_position;
            rec_started_next = 1'b1;
          end
          if (gap_below(tgt_pos_next, item.motor_position, SETTLE_WINDOW)) begin
            if (is_single) begin
              release_ticks_next = sat_inc(release_ticks);
            end else begin
              jam_kind_next = JAM_NONE;
              rec_done_next = 1'b1;
              jam_flag_next = 1'b0;
            end
          end
          if (is_single && release_ticks_next > cfg.release_tick_limit) begin
            jam_kind_next      = JAM_NONE;
            rec_done_next      = 1'b1;
            jam_flag_next      = 1'b0;
            release_ticks_next = 16'd0;
          end
        end
      end else begin
        case (fire_now)
          FIRE_SINGLE: begin
            if (fire_before == FIRE_BURST) tgt_pos_next = item.motor_position;
            if (single_req_next) begin
              single_req_next = 1'b0;
              if (power_short(item.shot_power, cfg.normal_power_margin, cfg.power_ceiling))
                tgt_pos_next = item.motor_position;
              else
                tgt_pos_next = tgt_pos_next + {12'd0, cfg.single_shot_step};
            end
          end
          FIRE_BURST: begin
            tgt_pos_next = item.motor_position;
            if (item.vision_lock)
              rate = item.vision_fire ? (item.target_outpost ? RATE_OUTPOST : RATE_FULL)
                                      : RATE_NONE;
            tgt_speed_next = SPEED_PER_RATE * {8'd0, rate};
          end
          default: begin
            if (gap_below(tgt_pos_next, item.motor_position, SHOT_DONE_WINDOW)) begin
              single_req_next = 1'b1;
              tgt_pos_next    = item.motor_position;
            end
          end
        endcase
        fire_before_next = fire_now;
      end
    end

    res.shot_mode       = fire_now;
    res.drive_mode      = !healthy ? DRIVE_OFF :
                          (fire_now == FIRE_BURST) ? DRIVE_SPEED : DRIVE_POSITION;
    res.position_target = tgt_pos_next;
    res.speed_target    = tgt_speed_next;
    res.jam_active      = jam_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fire_before   <= FIRE_IDLE;
      tgt_pos       <= 32'd0;
      tgt_speed     <= 13'd0;
      single_req    <= 1'b0;
      jam_flag      <= 1'b0;
      jam_kind      <= JAM_NONE;
      rec_done      <= 1'b1;
      rec_started   <= 1'b1;
      stall_ticks   <= 16'd0;
      release_ticks <= 16'd0;
    end else if (advance) begin
      fire_before   <= fire_before_next;
      tgt_pos       <= tgt_pos_next;
      tgt_speed     <= tgt_speed_next;
      single_req    <= single_req_next;
      jam_flag      <= jam_flag_next;
      jam_kind      <= jam_kind_next;
      rec_done      <= rec_done_next;
      rec_started   <= rec_started_next;
      stall_ticks   <= stall_ticks_next;
      release_ticks <= release_ticks_next;
    end
  end

endmodule

>>> sv/feeder_fire_and_jam_control.sv
// Top level of the feeder fire and jam control: input register, tick logic, result register.
//
//  channel | ports                                     | word
//  --------+-------------------------------------------+--------------------------------
//  input   | in_valid, in_ready, in_data               | one control tick (fjc_pkg::in_t)
//  output  | out_valid, out_ready, out_data            | one tick result (fjc_pkg::out_t)
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | register write, index 0..7
//
// One word per clock sustained while the output is not stalled; a word is caught in the input register
// when accepted, and its result loads the output register and raises out_valid when it advances.
// The rate is set by the tick state loop: each tick's state update is one combinational pass.
// rst is synchronous: clears both registers' valid bits, tick state and config to defaults.
// A stalled output holds its word; the input register keeps taking words as long as it is
// empty or the output register drains or is empty.
module feeder_fire_and_jam_control (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fjc_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fjc_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fjc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fjc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fjc_pkg::*;

  cfg_t cfg;
  in_t  in_reg;
  out_t res;
  logic in_held;
  logic advance;

  // config writes are registered, always ready
  assign cfg_ready = 1'b1;

  fjc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // held word moves on when the output register is free or being drained
  assign advance  = in_held && (!out_valid || out_ready);
  assign in_ready = !in_held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
  end

  fjc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cfg     (cfg),
    .item    (in_reg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

endmodule

>>> sv/fjc_checker.sv
// Port checker for the feeder fire and jam control, with its bind.
module fjc_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input fjc_pkg::out_t out_data
);
  import fjc_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // speed drive exactly when bursting
  a_burst_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.drive_mode == DRIVE_SPEED) == (out_data.shot_mode == FIRE_BURST)))
    else $error("drive mode does not match burst fire");

  a_off_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.drive_mode == DRIVE_OFF |-> out_data.shot_mode == FIRE_IDLE)
    else $error("fire mode not idle with drive off");

  a_speed_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.speed_target <= SPEED_TARGET_MAX)
    else $error("speed target out of range");

endmodule

bind feeder_fire_and_jam_control fjc_checker u_fjc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
